[design/bpa_pkg.sv]
// shared types, constants and helper functions of the bitmap page allocator
package bpa_pkg;

    localparam int BITMAP_DEPTH_BYTES_DEFAULT = 4096;

    localparam int BYTE_BITS  = 8;
    localparam int ROW_BYTES  = 8;
    localparam int ROW_BITS   = ROW_BYTES * BYTE_BITS;
    localparam int ROW_POS_W  = 6;
    localparam int PAGE_SHIFT = 12;
    localparam int VADDR_W    = 64;
    localparam int PAGE_IDX_W = VADDR_W - PAGE_SHIFT;
    localparam int PADDR_W    = 27;
    localparam int BYTES_W    = 13;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    localparam logic [BYTE_BITS-1:0] FULL_BYTE = 8'hFF;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [1:0] ST_DONE         = 2'd0;
    localparam logic [1:0] ST_NONE_FREE    = 2'd1;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_MAP_OFFSET   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_BYTES_IN_USE = 1'd1;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [VADDR_W-1:0]  virtual_address;
        logic [14:0]         page_number;
    } bpa_cmd_t;

    typedef struct packed {
        logic [PADDR_W-1:0]  physical_address;
        logic [1:0]          status;
    } bpa_result_t;

    function automatic int bpa_rows(input int depth_bytes);
        return (depth_bytes + ROW_BYTES - 1) / ROW_BYTES;
    endfunction

    function automatic int bpa_row_aw(input int depth_bytes);
        int rows;
        rows = (depth_bytes + ROW_BYTES - 1) / ROW_BYTES;
        return (rows > 1) ? $clog2(rows) : 1;
    endfunction

    function automatic logic [2:0] lowest_set8(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

[design/bitmap_page_allocator_core.sv]
// top level of the first-fit bitmap page allocator
//
// After reset the block sweeps the bitmap memory to all-used, one 64-bit row
// per cycle, and holds busy high throughout the sweep; configuration writes
// are taken during the sweep. An item is taken when start is high and busy is
// low; busy then stays high until its result is shown with done for one
// cycle. Free, reserve and release check the page index and, when it is in
// range, take a read-modify-write of one bitmap row; an index out of range
// gives its result without a write. Alloc scans one 64-bit row (8 bytes) per
// cycle through the memory read port and stops at the first row with a free
// page, or at the last row in use when none is free. A new item may be
// started in the cycle in which done is high.
module bitmap_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int BITMAP_DEPTH_BYTES = BITMAP_DEPTH_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bpa_cmd_t              cmd,
    output logic                  busy,
    output logic                  done,
    output bpa_result_t           result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROWS   = bpa_rows(BITMAP_DEPTH_BYTES);
    localparam int ROW_AW = bpa_row_aw(BITMAP_DEPTH_BYTES);

    logic [VADDR_W-1:0]  offset_reg;
    logic [BYTES_W-1:0]  bytes_in_use_reg;

    logic                ram_we;
    logic [ROW_AW-1:0]   ram_addr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_BITS-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg       <= '0;
            bytes_in_use_reg <= BYTES_W'(4096);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DIRECT_MAP_OFFSET:   offset_reg       <= cfg_data;
                REG_BITMAP_BYTES_IN_USE: bytes_in_use_reg <= cfg_data[BYTES_W-1:0];
                default:                 offset_reg       <= offset_reg;
            endcase
        end
    end

    bpa_ctrl #(
        .BITMAP_DEPTH_BYTES (BITMAP_DEPTH_BYTES)
    ) u_ctrl (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .cmd                 (cmd),
        .busy                (busy),
        .done                (done),
        .result              (result),
        .direct_map_offset   (offset_reg),
        .bitmap_bytes_in_use (bytes_in_use_reg),
        .ram_we              (ram_we),
        .ram_addr            (ram_addr),
        .ram_wdata           (ram_wdata),
        .ram_rdata           (ram_rdata)
    );

    bpa_bitmap_ram #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

[design/bpa_bitmap_ram.sv]
// single-port bitmap memory, one 64-bit row per access, registered read
module bpa_bitmap_ram
    import bpa_pkg::*;
#(
    parameter int ROWS   = bpa_rows(BITMAP_DEPTH_BYTES_DEFAULT),
    parameter int ROW_AW = bpa_row_aw(BITMAP_DEPTH_BYTES_DEFAULT)
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [ROW_AW-1:0]   addr,
    input  logic [ROW_BITS-1:0] wdata,
    output logic [ROW_BITS-1:0] rdata
);

    logic [ROW_BITS-1:0] mem [0:ROWS-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

[design/bpa_ctrl.sv]
// sequencer: clearing pass, first-fit row scan and read-modify-write of one row
module bpa_ctrl
    import bpa_pkg::*;
#(
    parameter int BITMAP_DEPTH_BYTES = BITMAP_DEPTH_BYTES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  bpa_cmd_t            cmd,
    output logic                busy,
    output logic                done,
    output bpa_result_t         result,
    input  logic [VADDR_W-1:0]  direct_map_offset,
    input  logic [BYTES_W-1:0]  bitmap_bytes_in_use,
    output logic                ram_we,
    output logic [bpa_row_aw(BITMAP_DEPTH_BYTES)-1:0] ram_addr,
    output logic [ROW_BITS-1:0] ram_wdata,
    input  logic [ROW_BITS-1:0] ram_rdata
);

    localparam int ROWS   = bpa_rows(BITMAP_DEPTH_BYTES);
    localparam int ROW_AW = bpa_row_aw(BITMAP_DEPTH_BYTES);
    localparam int CNT_W  = (ROW_AW + 4 > BYTES_W + 1) ? ROW_AW + 4 : BYTES_W + 1;
    localparam int PAGE_W = ROW_AW + ROW_POS_W;
    localparam int AF_W   = (PAGE_W + PAGE_SHIFT > PADDR_W) ? PAGE_W + PAGE_SHIFT : PADDR_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MODIFY,
        S_SCAN_FIRST,
        S_SCAN
    } state_t;

    state_t                  state_reg, state_next;
    logic [ROW_AW-1:0]       row_reg, row_next;
    logic [PAGE_IDX_W-1:0]   page_reg, page_next;
    logic [1:0]              op_reg, op_next;
    logic                    done_reg, done_next;
    bpa_result_t             result_reg, result_next;

    logic [CNT_W-1:0]        usable;
    logic [CNT_W-1:0]        next_base;
    logic                    last_row;
    logic [ROW_BYTES-1:0]    byte_ok;
    logic                    found;
    logic [2:0]              hit_byte;
    logic [2:0]              hit_bit;
    logic [BYTE_BITS-1:0]    sel_byte;
    logic [ROW_POS_W-1:0]    hit_pos;
    logic [PAGE_W-1:0]       page_found;
    logic [AF_W-1:0]         addr_full;
    logic [VADDR_W-1:0]      free_diff;
    logic                    in_range;
    logic [ROW_BITS-1:0]     rmw_mask;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // effective bitmap size in bytes
    always_comb
    begin
        if (CNT_W'(bitmap_bytes_in_use) < CNT_W'(BITMAP_DEPTH_BYTES))
        begin
            usable = CNT_W'(bitmap_bytes_in_use);
        end
        else
        begin
            usable = CNT_W'(BITMAP_DEPTH_BYTES);
        end
    end

    // first-fit search within the row currently on the read port
    always_comb
    begin
        for (int j = 0; j < ROW_BYTES; j++)
        begin
            byte_ok[j] = (CNT_W'({row_reg, 3'(j)}) < usable)
                      && (ram_rdata[BYTE_BITS*j +: BYTE_BITS] != FULL_BYTE);
        end
    end

    assign next_base  = CNT_W'({row_reg, 3'b000}) + CNT_W'(ROW_BYTES);
    assign last_row   = (next_base >= usable);
    assign found      = |byte_ok;
    assign hit_byte   = lowest_set8(byte_ok);
    assign sel_byte   = ram_rdata[{hit_byte, 3'b000} +: BYTE_BITS];
    assign hit_bit    = lowest_set8(~sel_byte);
    assign hit_pos    = {hit_byte, hit_bit};
    assign page_found = {row_reg, hit_pos};
    assign addr_full  = AF_W'({page_found, {PAGE_SHIFT{1'b0}}});

    assign free_diff  = cmd.virtual_address - direct_map_offset;
    assign in_range   = (page_reg[PAGE_IDX_W-1:3] < (PAGE_IDX_W-3)'(usable));
    assign rmw_mask   = ROW_BITS'(1) << page_reg[ROW_POS_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        page_next   = page_reg;
        op_next     = op_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_addr    = row_reg;
        ram_wdata   = ram_rdata;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {ROW_BITS{1'b1}};
                row_next  = row_reg + 1'b1;
                if (row_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.opcode;
                    row_next = '0;
                    if (cmd.opcode == OP_FREE)
                    begin
                        page_next = free_diff[VADDR_W-1:PAGE_SHIFT];
                    end
                    else
                    begin
                        page_next = PAGE_IDX_W'(cmd.page_number);
                    end
                    if (cmd.opcode == OP_ALLOC)
                    begin
                        state_next = S_SCAN_FIRST;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                ram_addr = page_reg[ROW_AW+ROW_POS_W-1:ROW_POS_W];
                if (in_range)
                begin
                    state_next = S_MODIFY;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{physical_address: '0, status: ST_OUT_OF_RANGE};
                    state_next  = S_IDLE;
                end
            end
            S_MODIFY:
            begin
                ram_we   = 1'b1;
                ram_addr = page_reg[ROW_AW+ROW_POS_W-1:ROW_POS_W];
                if (op_reg == OP_RESERVE)
                begin
                    ram_wdata = ram_rdata | rmw_mask;
                end
                else
                begin
                    ram_wdata = ram_rdata & ~rmw_mask;
                end
                done_next   = 1'b1;
                result_next = '{physical_address: '0, status: ST_DONE};
                state_next  = S_IDLE;
            end
            S_SCAN_FIRST:
            begin
                ram_addr   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (found)
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata | (ROW_BITS'(1) << hit_pos);
                    done_next   = 1'b1;
                    result_next = '{physical_address: addr_full[PADDR_W-1:0],
                                    status: ST_DONE};
                    state_next  = S_IDLE;
                end
                else if (last_row)
                begin
                    done_next   = 1'b1;
                    result_next = '{physical_address: '0, status: ST_NONE_FREE};
                    state_next  = S_IDLE;
                end
                else
                begin
                    // prefetch the next row while this one is checked
                    ram_addr = row_reg + 1'b1;
                    row_next = row_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            row_reg    <= '0;
            page_reg   <= '0;
            op_reg     <= OP_ALLOC;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            page_reg   <= page_next;
            op_reg     <= op_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

endmodule

[design/bpa_checker.sv]
// port-level checks of the page allocator and their binding to the top level
module bpa_checker
    import bpa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input bpa_result_t result
);

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after item accepted");

    // a result closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("result without a preceding busy period");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_DONE) || (result.status == ST_NONE_FREE)
              || (result.status == ST_OUT_OF_RANGE))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != ST_DONE) |-> (result.physical_address == '0))
        else $error("failed item returned a nonzero address");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[tb/bitmap_page_allocator_core_checker.sv]
// checker that tracks the page bitmap, predicts each result and compares it
module bitmap_page_allocator_core_checker
    import bpa_pkg::*;
#(
    parameter int BITMAP_DEPTH_BYTES = BITMAP_DEPTH_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  bpa_cmd_t              cmd,
    input  logic                  done,
    input  bpa_result_t           result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    awaited_count
);

    localparam int BYTES_RESET = 4096;

    logic [BYTE_BITS-1:0] used_map [BITMAP_DEPTH_BYTES];
    logic [VADDR_W-1:0]   map_offset;
    logic [BYTES_W-1:0]   bytes_in_use;
    bpa_result_t          awaited_results [$];
    int                   mismatches = 0;

    function automatic int unsigned usable_bytes();
        return (bytes_in_use > BITMAP_DEPTH_BYTES) ? BITMAP_DEPTH_BYTES : bytes_in_use;
    endfunction

    function automatic logic [1:0] write_page_bit(input logic [PAGE_IDX_W-1:0] pg,
                                                  input logic used);
        logic [PAGE_IDX_W-1:0] byte_ix;
        byte_ix = pg >> 3;
        if (byte_ix >= usable_bytes())
        begin
            return ST_OUT_OF_RANGE;
        end
        used_map[byte_ix][pg[2:0]] = used;
        return ST_DONE;
    endfunction

    function automatic bpa_result_t apply_page_op(input bpa_cmd_t c);
        bpa_result_t        r;
        logic [VADDR_W-1:0] diff;
        bit                 found;
        r = '0;
        r.status = ST_DONE;
        case (c.opcode)
            OP_ALLOC:
            begin
                found = 1'b0;
                for (int i = 0; i < usable_bytes() && !found; i++)
                begin
                    if (used_map[i] != FULL_BYTE)
                    begin
                        for (int b = 0; b < BYTE_BITS && !found; b++)
                        begin
                            if (!used_map[i][b])
                            begin
                                used_map[i][b] = 1'b1;
                                r.physical_address = PADDR_W'((i * BYTE_BITS + b) << PAGE_SHIFT);
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (!found)
                begin
                    r.status = ST_NONE_FREE;
                end
            end
            OP_FREE:
            begin
                diff = c.virtual_address - map_offset;
                r.status = write_page_bit(diff[VADDR_W-1:PAGE_SHIFT], 1'b0);
            end
            OP_RESERVE:
            begin
                r.status = write_page_bit(PAGE_IDX_W'(c.page_number), 1'b1);
            end
            default:
            begin
                r.status = write_page_bit(PAGE_IDX_W'(c.page_number), 1'b0);
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        bpa_result_t want;
        if (!rst_n)
        begin
            foreach (used_map[i])
            begin
                used_map[i] = FULL_BYTE;
            end
            map_offset = '0;
            bytes_in_use = BYTES_W'(BYTES_RESET);
            awaited_results.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_DIRECT_MAP_OFFSET)
                begin
                    map_offset = cfg_data;
                end
                else
                begin
                    bytes_in_use = cfg_data[BYTES_W-1:0];
                end
            end
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: physical_address %0h status %0d",
                           result.physical_address, result.status);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.physical_address !== want.physical_address)
                    begin
                        $error("physical_address expected %0h actual %0h",
                               want.physical_address, result.physical_address);
                        mismatches++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, result.status);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                awaited_results.push_back(apply_page_op(cmd));
            end
        end
        fail_count <= mismatches;
        awaited_count <= awaited_results.size();
    end

endmodule

[tb/bitmap_page_allocator_core_test.sv]
// top of the page allocator testbench: clock, reset, stimulus and verdict
module bitmap_page_allocator_core_test;
    import bpa_pkg::*;

    localparam int          LIMIT_CYCLES = 3000000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_BYTES    = BITMAP_DEPTH_BYTES_DEFAULT;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] HIGH_HALF    = 64'hFFFF_8000_0000_0000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    bpa_cmd_t              cmd       = '0;
    logic                  busy;
    logic                  done;
    bpa_result_t           result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    pending_results;

    logic [63:0]           cur_offset = '0;
    int unsigned           cur_span   = MAX_BYTES * BYTE_BITS;
    bit                    steady     = 1'b0;
    int unsigned           cycle_count = 0;

    bitmap_page_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bitmap_page_allocator_core_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .result        (result),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .awaited_count (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bpa_cmd_t make_cmd(input logic [1:0] op, input logic [63:0] va,
                                          input logic [14:0] pg);
        bpa_cmd_t c;
        c.opcode = op;
        c.virtual_address = va;
        c.page_number = pg;
        return c;
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic bpa_cmd_t random_cmd();
        bpa_cmd_t    c;
        int unsigned sel;
        c.virtual_address = {$urandom, $urandom};
        c.page_number = 15'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            c.opcode = OP_ALLOC;
        end
        else if (sel < 60)
        begin
            c.opcode = OP_FREE;
            if ($urandom_range(0, 9) < 8 && cur_span > 0)
            begin
                c.virtual_address = cur_offset
                    + (64'($urandom_range(0, cur_span - 1)) << PAGE_SHIFT)
                    + 64'($urandom_range(0, 4095));
            end
        end
        else
        begin
            c.opcode = (sel < 75) ? OP_RESERVE : OP_RELEASE;
            sel = $urandom_range(0, 9);
            if (sel < 8 && cur_span > 0)
            begin
                c.page_number = 15'($urandom_range(0, cur_span - 1));
            end
            else if (sel == 8)
            begin
                c.page_number = 15'(cur_span + $urandom_range(0, 7));
            end
        end
        return c;
    endfunction

    task automatic issue(input bpa_cmd_t c);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [63:0] offset, input int unsigned nbytes);
        quiesce();
        write_reg(REG_DIRECT_MAP_OFFSET, offset);
        write_reg(REG_BITMAP_BYTES_IN_USE, {51'({$urandom, $urandom}), BYTES_W'(nbytes)});
        cur_offset = offset;
        cur_span = ((nbytes > MAX_BYTES) ? MAX_BYTES : nbytes) * BYTE_BITS;
    endtask

    task automatic run_phase(input logic [63:0] offset, input int unsigned nbytes,
                             input int count);
        set_config(offset, nbytes);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                steady = !steady;
            end
            issue(random_cmd());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // full bitmap after reset, page zero and the last page
        issue(make_cmd(OP_ALLOC, '0, '0));
        issue(make_cmd(OP_RELEASE, '0, 15'd0));
        issue(make_cmd(OP_RELEASE, '0, 15'd32767));
        issue(make_cmd(OP_ALLOC, '0, '0));
        issue(make_cmd(OP_ALLOC, '0, '0));
        issue(make_cmd(OP_ALLOC, '0, '0));
        issue(make_cmd(OP_FREE, 64'h3000, '0));
        issue(make_cmd(OP_ALLOC, '0, '0));
        issue(make_cmd(OP_FREE, ALL_ONES, '0));
        issue(make_cmd(OP_RESERVE, '0, 15'd32767));
        issue(make_cmd(OP_RELEASE, '0, 15'd12345));
        issue(make_cmd(OP_RESERVE, '0, 15'd12345));

        // one usable byte behind a higher-half offset
        set_config(HIGH_HALF, 1);
        issue(make_cmd(OP_FREE, HIGH_HALF + 64'h5FFF, '0));
        issue(make_cmd(OP_FREE, '0, '0));
        issue(make_cmd(OP_RELEASE, '0, 15'd8));
        issue(make_cmd(OP_RESERVE, '0, 15'd32767));
        issue(make_cmd(OP_ALLOC, '0, '0));
        issue(make_cmd(OP_ALLOC, '0, '0));

        // no usable bytes at all
        set_config(ALL_ONES, 0);
        issue(make_cmd(OP_ALLOC, '0, '0));
        issue(make_cmd(OP_RELEASE, '0, 15'd0));
        issue(make_cmd(OP_FREE, ALL_ONES, '0));
        issue(make_cmd(OP_RESERVE, '0, 15'd0));

        run_phase(64'h0, 1, 100);
        run_phase({$urandom, $urandom}, 2, 120);
        run_phase(ALL_ONES, 8, 150);
        run_phase({$urandom, $urandom}, 16, 150);
        run_phase(HIGH_HALF, 64, 150);
        run_phase({$urandom, $urandom}, 0, 40);
        run_phase({$urandom, $urandom}, 4095, 60);
        run_phase({$urandom, $urandom}, 8191, 60);
        run_phase({$urandom, $urandom}, 4096, 60);
        run_phase(64'h0, 3, 150);
        run_phase({$urandom, $urandom}, 32, 100);

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("bitmap_page_allocator_core verification clean");
        else
            $display("bitmap_page_allocator_core verification failed");
        $finish;
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bitmap_page_allocator_core verification failed");
        $finish;
    end

endmodule

[sim.f]
design/bpa_pkg.sv
design/bpa_bitmap_ram.sv
design/bpa_ctrl.sv
design/bitmap_page_allocator_core.sv
design/bpa_checker.sv
tb/bitmap_page_allocator_core_checker.sv
tb/bitmap_page_allocator_core_test.sv
